// ===== hdl/i8svx_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// i8svx_pkg
// Types and constants shared by the 8SVX chunk parser modules.
// ----------------------------------------------------------------------------
package i8svx_pkg;

  localparam logic [31:0] TAG_FORM = 32'h464F_524D;
  localparam logic [31:0] TAG_8SVX = 32'h3853_5658;
  localparam logic [31:0] TAG_VHDR = 32'h5648_4452;
  localparam logic [31:0] TAG_BODY = 32'h424F_4459;

  localparam logic [7:0]  SAMPLE_BIAS = 8'd128;
  localparam logic [4:0]  VHDR_LAST   = 5'd17;
  localparam logic [4:0]  COUNT_BYTE  = 5'd3;
  localparam logic [4:0]  RATE_BYTE   = 5'd13;
  localparam logic [4:0]  FIELD_LAST  = 5'd3;
  localparam logic [32:0] POS_MAX     = 33'h1_FFFF_FFFF;
  localparam logic [32:0] FORM_HDR    = 33'd8;

  typedef enum logic [3:0] {
    PH_FORM,
    PH_FLEN,
    PH_TYPE,
    PH_CID,
    PH_CSIZE,
    PH_VHDR,
    PH_SKIP,
    PH_BODY,
    PH_FINISHED,
    PH_BADFORM,
    PH_BADTYPE
  } phase_t;

  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_INFO   = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;
  localparam logic [1:0] KIND_DONE   = 2'd3;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_BAD_FORM  = 3'd1;
  localparam logic [2:0] ERR_BAD_TYPE  = 3'd2;
  localparam logic [2:0] ERR_TRUNCATED = 3'd3;
  localparam logic [2:0] ERR_NO_BODY   = 3'd4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        result_kind;
    logic signed [7:0] sample_value;
    logic [15:0]       sample_rate;
    logic [31:0]       sample_count;
    logic [2:0]        error_code;
  } out_item_t;

endpackage
`default_nettype wire

// ===== hdl/i8svx_parse.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// i8svx_parse
// Parser state and one-byte step: tag and size fields, VHDR header, BODY
// samples, chunk skipping and the end-of-file verdict.
// ----------------------------------------------------------------------------
module i8svx_parse
  import i8svx_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step,
  input  in_item_t  item,
  output logic      res_valid,
  output out_item_t res
);

  phase_t      phase_r, phase_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [31:0] tag_r, tag_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [32:0] fend_r, fend_nxt;
  logic [32:0] pos_r, pos_nxt;
  logic [31:0] count_r, count_nxt;
  logic [15:0] rate_r, rate_nxt;
  logic        body_r, body_nxt;

  logic [31:0] tag_sh;
  logic [31:0] rem_sh;
  logic [31:0] rem_dec;
  logic [4:0]  cnt_inc;
  phase_t      done_phase;
  logic [1:0]  kind;
  logic [7:0]  sv;
  logic [2:0]  code;
  logic        has_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_FORM;
      cnt_r   <= '0;
      tag_r   <= '0;
      rem_r   <= '0;
      fend_r  <= '0;
      pos_r   <= '0;
      count_r <= '0;
      rate_r  <= '0;
      body_r  <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      tag_r   <= tag_nxt;
      rem_r   <= rem_nxt;
      fend_r  <= fend_nxt;
      pos_r   <= pos_nxt;
      count_r <= count_nxt;
      rate_r  <= rate_nxt;
      body_r  <= body_nxt;
    end
  end

  always_comb begin
    tag_sh     = {tag_r[23:0], item.data_byte};
    rem_sh     = {rem_r[23:0], item.data_byte};
    rem_dec    = (rem_r != '0) ? (rem_r - 32'd1) : rem_r;
    cnt_inc    = cnt_r + 5'd1;
    pos_nxt    = (pos_r != POS_MAX) ? (pos_r + 33'd1) : pos_r;
    done_phase = (pos_nxt >= fend_r) ? PH_FINISHED : PH_CID;

    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    tag_nxt   = tag_r;
    rem_nxt   = rem_r;
    fend_nxt  = fend_r;
    count_nxt = count_r;
    rate_nxt  = rate_r;
    body_nxt  = body_r;
    has_res   = 1'b0;
    kind      = KIND_SAMPLE;
    sv        = '0;
    code      = ERR_NONE;

    case (phase_r)
      PH_FORM, PH_TYPE, PH_CID: begin
        tag_nxt = tag_sh;
        cnt_nxt = cnt_inc;
        if (cnt_r == FIELD_LAST) begin
          cnt_nxt = '0;
          if (phase_r == PH_FORM) begin
            phase_nxt = (tag_sh != TAG_FORM) ? PH_BADFORM : PH_FLEN;
          end else if (phase_r == PH_TYPE) begin
            phase_nxt = (tag_sh != TAG_8SVX) ? PH_BADTYPE : done_phase;
          end else begin
            phase_nxt = PH_CSIZE;
          end
        end
      end
      PH_FLEN, PH_CSIZE: begin
        rem_nxt = rem_sh;
        cnt_nxt = cnt_inc;
        if (cnt_r == FIELD_LAST) begin
          cnt_nxt = '0;
          if (phase_r == PH_FLEN) begin
            fend_nxt  = {1'b0, rem_sh} + FORM_HDR;
            phase_nxt = PH_TYPE;
          end else if (tag_r == TAG_VHDR) begin
            phase_nxt = PH_VHDR;
          end else if (tag_r == TAG_BODY) begin
            body_nxt  = 1'b1;
            phase_nxt = (rem_sh != '0) ? PH_BODY : done_phase;
          end else begin
            phase_nxt = (rem_sh != '0) ? PH_SKIP : done_phase;
          end
        end
      end
      PH_VHDR: begin
        tag_nxt = tag_sh;
        rem_nxt = rem_dec;
        if (cnt_r == COUNT_BYTE) begin
          count_nxt = tag_sh;
        end
        if (cnt_r == RATE_BYTE) begin
          rate_nxt = tag_sh[15:0];
          has_res  = 1'b1;
          kind     = KIND_INFO;
        end
        cnt_nxt = cnt_inc;
        if (cnt_r == VHDR_LAST) begin
          cnt_nxt   = '0;
          phase_nxt = (rem_dec != '0) ? PH_SKIP : done_phase;
        end
      end
      PH_SKIP, PH_BODY: begin
        if (phase_r == PH_BODY) begin
          sv      = item.data_byte - SAMPLE_BIAS;
          has_res = 1'b1;
          kind    = KIND_SAMPLE;
        end
        rem_nxt = rem_dec;
        if (rem_dec == '0) begin
          cnt_nxt   = '0;
          phase_nxt = done_phase;
        end
      end
      default: begin
      end
    endcase

    if (item.last_byte) begin
      if (!(has_res && kind == KIND_SAMPLE)) begin
        sv = '0;
      end
      case (phase_nxt)
        PH_BADFORM:  code = ERR_BAD_FORM;
        PH_BADTYPE:  code = ERR_BAD_TYPE;
        PH_FINISHED: code = body_nxt ? ERR_NONE : ERR_NO_BODY;
        default:     code = ERR_TRUNCATED;
      endcase
      has_res = 1'b1;
      kind    = (code == ERR_NONE) ? KIND_DONE : KIND_ERROR;
    end

    res_valid        = has_res;
    res.result_kind  = kind;
    res.sample_value = sv;
    res.sample_rate  = rate_nxt;
    res.sample_count = count_nxt;
    res.error_code   = code;

    if (item.last_byte) begin
      phase_nxt = PH_FORM;
      cnt_nxt   = '0;
      tag_nxt   = '0;
      rem_nxt   = '0;
      fend_nxt  = '0;
      pos_nxt   = '0;
      count_nxt = '0;
      rate_nxt  = '0;
      body_nxt  = 1'b0;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/iff_8svx_chunk_parser_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// iff_8svx_chunk_parser_top
// Byte-stream parser for IFF 8SVX files.
//
// Input channel in_*: one file byte per transfer, with last_byte set on the
// final byte of the file. Output channel out_*: at most one result per byte:
// a signed sample for each BODY byte, format info once per VHDR header, and
// a done or error verdict on the last byte. After the last byte the parser
// starts over for the next file.
// A byte is registered in the input register at its transfer, and its result
// is loaded from the parser into the output register when the parser steps.
// Throughput: one byte per cycle, set by the parser's state update, while
// out_stall does not block a pending result.
// A stalled result holds in the output register; the parser keeps working
// while the output register is free or being drained, and a full input
// register raises in_stall only while out_stall blocks a pending result.
// Reset clears the parser state and both valid flags; in_stall is low.
// ----------------------------------------------------------------------------
module iff_8svx_chunk_parser_top
  import i8svx_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic      s1_valid_r;
  in_item_t  s1_item_r;
  logic      out_valid_r;
  out_item_t out_item_r;

  logic      out_free;
  logic      adv;
  logic      res_valid;
  out_item_t res;

  assign out_free = !out_valid_r || !out_stall;
  assign adv      = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;

  i8svx_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (adv),
    .item      (s1_item_r),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= adv && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res_valid) begin
      out_item_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

endmodule
`default_nettype wire

// ===== dv/testbench.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the IFF 8SVX chunk parser.
//
// Drives whole files one byte per transfer: a short directed table first,
// then random files, most of them well formed with random chunk mixes and
// the rest noise, broken tags, bad form lengths, truncation and trailing
// bytes. An in-bench parser model predicts the random files' results. Each
// result transfer is checked field by field against the oldest prediction.
// Both channels idle in random bursts; the receiver holds off once long
// enough to back up the parser, and the sender drains all results.
// ----------------------------------------------------------------------------
module testbench;
  import i8svx_pkg::*;

  localparam int TOTAL_BYTES = 1400;
  localparam int CALM_AFTER  = 1250;
  localparam int CYCLE_LIMIT = 500000;
  localparam int HOLD_CYCLES = 200;
  localparam int NUM_ROWS    = 25;

  typedef struct packed {
    in_item_t  item;
    logic      typed;
    out_item_t want;
  } row_t;

  // a one-byte file, a broken FORM tag, then an empty BODY file that closes exactly at the form end
  localparam row_t DIRECTED_ROWS [NUM_ROWS] = '{
    '{'{8'hFF, 1'b1}, 1'b1, '{KIND_ERROR, 8'sd0, 16'd0, 32'd0, ERR_TRUNCATED}},
    '{'{8'h46, 1'b0}, 1'b0, '0},
    '{'{8'h4F, 1'b0}, 1'b0, '0},
    '{'{8'h52, 1'b0}, 1'b0, '0},
    '{'{8'h00, 1'b1}, 1'b1, '{KIND_ERROR, 8'sd0, 16'd0, 32'd0, ERR_BAD_FORM}},
    '{'{8'h46, 1'b0}, 1'b0, '0},
    '{'{8'h4F, 1'b0}, 1'b0, '0},
    '{'{8'h52, 1'b0}, 1'b0, '0},
    '{'{8'h4D, 1'b0}, 1'b0, '0},
    '{'{8'h00, 1'b0}, 1'b0, '0},
    '{'{8'h00, 1'b0}, 1'b0, '0},
    '{'{8'h00, 1'b0}, 1'b0, '0},
    '{'{8'h0C, 1'b0}, 1'b0, '0},
    '{'{8'h38, 1'b0}, 1'b0, '0},
    '{'{8'h53, 1'b0}, 1'b0, '0},
    '{'{8'h56, 1'b0}, 1'b0, '0},
    '{'{8'h58, 1'b0}, 1'b0, '0},
    '{'{8'h42, 1'b0}, 1'b0, '0},
    '{'{8'h4F, 1'b0}, 1'b0, '0},
    '{'{8'h44, 1'b0}, 1'b0, '0},
    '{'{8'h59, 1'b0}, 1'b0, '0},
    '{'{8'h00, 1'b0}, 1'b0, '0},
    '{'{8'h00, 1'b0}, 1'b0, '0},
    '{'{8'h00, 1'b0}, 1'b0, '0},
    '{'{8'h00, 1'b1}, 1'b1, '{KIND_DONE, 8'sd0, 16'd0, 32'd0, ERR_NONE}}
  };

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  iff_8svx_chunk_parser_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // parser model state
  phase_t      ph;
  logic [4:0]  fcount;
  logic [31:0] tag;
  logic [31:0] remain;
  logic [32:0] form_end;
  logic [32:0] pos;
  logic [31:0] held_count;
  logic [15:0] held_rate;
  logic        body_seen;

  out_item_t   pending_results [$];
  out_item_t   oldest_expected;
  logic [7:0]  file_bytes [$];
  int          failures = 0;
  int          bytes_sent = 0;
  int          cycles = 0;
  bit          calm = 1'b0;
  bit          sender_idles = 1'b0;
  bit          hold_off_request = 1'b0;
  bit          receiver_holding = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void parser_clear();
    ph         = PH_FORM;
    fcount     = '0;
    tag        = '0;
    remain     = '0;
    form_end   = '0;
    pos        = '0;
    held_count = '0;
    held_rate  = '0;
    body_seen  = 1'b0;
  endfunction

  function automatic void close_chunk();
    fcount = '0;
    ph = (pos >= form_end) ? PH_FINISHED : PH_CID;
  endfunction

  function automatic bit parse_byte(input in_item_t it, output out_item_t res);
    logic [7:0] b;
    logic [1:0] kind;
    logic [7:0] sv;
    logic [2:0] code;
    bit         emit;
    b    = it.data_byte;
    kind = KIND_SAMPLE;
    sv   = '0;
    code = ERR_NONE;
    emit = 1'b0;
    if (pos != POS_MAX) pos = pos + 33'd1;
    case (ph)
      PH_FORM, PH_TYPE, PH_CID: begin
        tag = {tag[23:0], b};
        if (fcount == FIELD_LAST) begin
          fcount = '0;
          if (ph == PH_FORM) begin
            ph = (tag == TAG_FORM) ? PH_FLEN : PH_BADFORM;
          end else if (ph == PH_TYPE) begin
            if (tag != TAG_8SVX) ph = PH_BADTYPE;
            else close_chunk();
          end else begin
            ph = PH_CSIZE;
          end
        end else begin
          fcount = fcount + 5'd1;
        end
      end
      PH_FLEN, PH_CSIZE: begin
        remain = {remain[23:0], b};
        if (fcount == FIELD_LAST) begin
          fcount = '0;
          if (ph == PH_FLEN) begin
            form_end = {1'b0, remain} + FORM_HDR;
            ph = PH_TYPE;
          end else if (tag == TAG_VHDR) begin
            ph = PH_VHDR;
          end else if (tag == TAG_BODY) begin
            body_seen = 1'b1;
            if (remain != 0) ph = PH_BODY;
            else close_chunk();
          end else begin
            if (remain != 0) ph = PH_SKIP;
            else close_chunk();
          end
        end else begin
          fcount = fcount + 5'd1;
        end
      end
      PH_VHDR: begin
        tag = {tag[23:0], b};
        if (remain != 0) remain = remain - 32'd1;
        if (fcount == COUNT_BYTE) held_count = tag;
        if (fcount == RATE_BYTE) begin
          held_rate = tag[15:0];
          kind = KIND_INFO;
          emit = 1'b1;
        end
        if (fcount == VHDR_LAST) begin
          fcount = '0;
          if (remain != 0) ph = PH_SKIP;
          else close_chunk();
        end else begin
          fcount = fcount + 5'd1;
        end
      end
      PH_SKIP, PH_BODY: begin
        if (ph == PH_BODY) begin
          sv   = b - SAMPLE_BIAS;
          kind = KIND_SAMPLE;
          emit = 1'b1;
        end
        if (remain != 0) remain = remain - 32'd1;
        if (remain == 0) close_chunk();
      end
      default: ;
    endcase
    if (it.last_byte) begin
      if (!(emit && kind == KIND_SAMPLE)) sv = '0;
      case (ph)
        PH_BADFORM:  code = ERR_BAD_FORM;
        PH_BADTYPE:  code = ERR_BAD_TYPE;
        PH_FINISHED: code = body_seen ? ERR_NONE : ERR_NO_BODY;
        default:     code = ERR_TRUNCATED;
      endcase
      kind = (code == ERR_NONE) ? KIND_DONE : KIND_ERROR;
      emit = 1'b1;
    end
    res = '{kind, sv, held_rate, held_count, code};
    if (it.last_byte) parser_clear();
    return emit;
  endfunction

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      failures++;
      $display("%0t: %s mismatch, expected %0h got %0h", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        failures++;
        $display("%0t: unexpected result, expected none got %0h", $time, out_data);
      end else begin
        oldest_expected = pending_results.pop_front();
        check_field("result_kind", 32'(oldest_expected.result_kind),
                    32'(out_data.result_kind));
        check_field("sample_value", 32'(oldest_expected.sample_value),
                    32'(out_data.sample_value));
        check_field("sample_rate", 32'(oldest_expected.sample_rate),
                    32'(out_data.sample_rate));
        check_field("sample_count", oldest_expected.sample_count, out_data.sample_count);
        check_field("error_code", 32'(oldest_expected.error_code),
                    32'(out_data.error_code));
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("%0t: timeout, %0d results outstanding", $time, pending_results.size());
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // receiver: one stall decision per burst
  initial begin
    out_stall <= 1'b0;
    forever begin
      if (calm) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else if (hold_off_request) begin
        hold_off_request = 1'b0;
        receiver_holding = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        receiver_holding = 1'b0;
      end else if ($urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end
    end
  end

  task automatic send_byte(input in_item_t it, input logic typed, input out_item_t want);
    out_item_t res;
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (parse_byte(it, res) && !typed) pending_results.push_back(res);
    if (typed) pending_results.push_back(want);
    bytes_sent++;
    if (sender_idles && !calm && !hold_off_request && !receiver_holding &&
        $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic put_word(input logic [31:0] w);
    file_bytes.push_back(w[31:24]);
    file_bytes.push_back(w[23:16]);
    file_bytes.push_back(w[15:8]);
    file_bytes.push_back(w[7:0]);
  endtask

  task automatic put_random(input int n);
    repeat (n) file_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic build_file();
    int          shape;
    int          k;
    int          sz;
    int          idx;
    logic [31:0] form_len;
    file_bytes.delete();
    shape = $urandom_range(0, 99);
    if (shape < 8) begin
      put_random($urandom_range(1, 24));
      return;
    end
    put_word(TAG_FORM);
    put_word('0);
    put_word(TAG_8SVX);
    for (k = $urandom_range(0, 4); k > 0; k--) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          sz = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 17) : $urandom_range(18, 26);
          put_word(TAG_VHDR);
          put_word(sz);
          put_random((sz < 18) ? 18 : sz);
        end
        3, 4, 5, 6: begin
          sz = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
          put_word(TAG_BODY);
          put_word(sz);
          put_random(sz);
        end
        default: begin
          sz = $urandom_range(0, 12);
          put_word($urandom);
          put_word(sz);
          put_random(sz);
        end
      endcase
    end
    if ($urandom_range(0, 19) == 0) begin
      put_word(($urandom_range(0, 1) == 0) ? TAG_BODY : TAG_VHDR);
      put_word($urandom | 32'h8000_0000);
      put_random($urandom_range(0, 20));
    end
    form_len = file_bytes.size() - 8;
    case ($urandom_range(0, 19))
      0, 1: form_len = form_len - $urandom_range(1, form_len);
      2, 3: form_len = form_len + $urandom_range(1, 20);
      4:    form_len = $urandom;
      5:    form_len = 32'hFFFF_FFFF;
      default: ;
    endcase
    file_bytes[4] = form_len[31:24];
    file_bytes[5] = form_len[23:16];
    file_bytes[6] = form_len[15:8];
    file_bytes[7] = form_len[7:0];
    if (shape < 14) begin
      idx = $urandom_range(0, 7);
      if (idx >= 4) idx += 4;
      file_bytes[idx] = file_bytes[idx] ^ (8'h01 << $urandom_range(0, 7));
    end
    if ($urandom_range(0, 9) == 0) put_random($urandom_range(1, 6));
    if ($urandom_range(0, 9) == 0) begin
      sz = $urandom_range(1, file_bytes.size());
      while (file_bytes.size() > sz) void'(file_bytes.pop_back());
    end
  endtask

  initial begin
    int i;
    int k;
    int file_idx;
    parser_clear();
    in_valid <= 1'b0;
    in_data  <= '0;
    rst_n    <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    sender_idles = 1'b1;
    for (i = 0; i < NUM_ROWS; i++)
      send_byte(DIRECTED_ROWS[i].item, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
    drain_results();

    file_idx = 0;
    while (bytes_sent < TOTAL_BYTES) begin
      build_file();
      if (file_idx == 3) hold_off_request = 1'b1;
      if (file_idx == 12) drain_results();
      calm = (bytes_sent > CALM_AFTER);
      sender_idles = ($urandom_range(0, 3) != 0);
      for (k = 0; k < file_bytes.size(); k++)
        send_byte('{file_bytes[k], k == file_bytes.size() - 1}, 1'b0, '0);
      file_idx++;
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
